FILE: rtl/integer_alu_with_flags_macros.svh
// Assertion macros for the integer ALU checker.
`ifndef INTEGER_ALU_WITH_FLAGS_MACROS_SVH
`define INTEGER_ALU_WITH_FLAGS_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define IALU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Implication after a fixed number of cycles.
`define IALU_ASSERT_DELAY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##n (cons)) else $error(msg);

`endif

FILE: rtl/ialu_pkg.sv
package ialu_pkg;

    // Fixed field widths
    localparam int DATA_W   = 64;
    localparam int OPCODE_W = 3;
    localparam int SIZE_W   = 2;
    localparam int EXT_W    = 2;

    // Widest operand the datapath runs at (8..64)
    localparam int MAX_WIDTH = 64;
    // Holds an operand width up to 64
    localparam int WIDTH_W   = 7;
    localparam int TOP_W     = 6;

    // Smallest operand width, shifted left by the size code
    localparam logic [WIDTH_W-1:0] BASE_WIDTH = WIDTH_W'(8);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD = 3'd0,
        OP_ADC = 3'd1,
        OP_SUB = 3'd2,
        OP_SBB = 3'd3,
        OP_CMP = 3'd4,
        OP_AND = 3'd5,
        OP_OR  = 3'd6,
        OP_XOR = 3'd7
    } t_opcode;

    typedef enum logic [EXT_W-1:0] {
        EXT_NONE = 2'd0,
        EXT_8    = 2'd1,
        EXT_16   = 2'd2,
        EXT_32   = 2'd3
    } t_ext;

    // Status flags, CF in bit 0 up to OF in bit 5
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } t_flags;

endpackage

FILE: rtl/ialu_op_if.sv
interface ialu_op_if;
    logic                                valid;
    logic                                ready;
    logic [ialu_pkg::OPCODE_W-1:0]       opcode;
    logic [ialu_pkg::SIZE_W-1:0]         operand_size;
    logic [ialu_pkg::DATA_W-1:0]         operand_a;
    logic [ialu_pkg::DATA_W-1:0]         operand_b;
    logic [ialu_pkg::EXT_W-1:0]          extend_source;

    modport source (
        output valid, opcode, operand_size, operand_a, operand_b, extend_source,
        input  ready
    );
    modport sink (
        input  valid, opcode, operand_size, operand_a, operand_b, extend_source,
        output ready
    );
endinterface

FILE: rtl/ialu_res_if.sv
interface ialu_res_if;
    logic                          valid;
    logic                          ready;
    logic [ialu_pkg::DATA_W-1:0]   result_value;
    logic                          write_back;
    logic                          carry_out;
    logic                          parity_out;
    logic                          aux_carry_out;
    logic                          zero_out;
    logic                          sign_out;
    logic                          overflow_out;

    modport source (
        output valid, result_value, write_back, carry_out, parity_out,
               aux_carry_out, zero_out, sign_out, overflow_out,
        input  ready
    );
    modport sink (
        input  valid, result_value, write_back, carry_out, parity_out,
               aux_carry_out, zero_out, sign_out, overflow_out,
        output ready
    );
endinterface

FILE: rtl/integer_alu_with_flags.sv
// Channel  | Dir | Payload                                                   | Beat
// ---------+-----+-----------------------------------------------------------+--------------
// i_op     | in  | opcode, operand_size, operand_a, operand_b, extend_source | valid & ready
// o_res    | out | result_value, write_back, CF, PF, AF, ZF, SF, OF flags    | valid & ready
//
// One beat per cycle while o_res is not stalled. A result passes the input
// register, then the ALU logic into the result register, before it leaves.
// Flags update as an operation enters the result register, so an adc or sbb
// right behind another operation sees that operation's carry.
// i_rst_n (synchronous, active low) empties both stages and clears the flags.
// A stall on o_res holds the result; i_op takes one more beat, then backs up.
module integer_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ialu_op_if.sink     i_op,
    ialu_res_if.source  o_res
);
    import ialu_pkg::*;

    // Input stage
    logic                r_in_valid;
    logic                n_in_valid;
    t_opcode             r_opcode;
    logic [SIZE_W-1:0]   r_operand_size;
    logic [DATA_W-1:0]   r_operand_a;
    logic [DATA_W-1:0]   r_operand_b;
    t_ext                r_extend_source;

    // Result stage
    logic                r_out_valid;
    logic                n_out_valid;
    logic [DATA_W-1:0]   r_result_value;
    logic                r_write_back;
    t_flags              r_out_flags;

    // Architectural flags
    t_flags              r_flags;
    t_flags              n_flags;

    logic                in_beat;
    logic                advance;
    logic [DATA_W-1:0]   alu_result;
    logic                alu_write_back;
    t_flags              alu_flags;

    // Result register free or draining this cycle
    assign advance   = r_in_valid & (~r_out_valid | o_res.ready);
    assign i_op.ready = ~r_in_valid | advance;
    assign in_beat   = i_op.valid & i_op.ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        n_flags     = r_flags;
        if (in_beat) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        if (advance) begin
            n_out_valid = 1'b1;
            n_flags     = alu_flags;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_flags     <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_opcode        <= t_opcode'(i_op.opcode);
            r_operand_size  <= i_op.operand_size;
            r_operand_a     <= i_op.operand_a;
            r_operand_b     <= i_op.operand_b;
            r_extend_source <= t_ext'(i_op.extend_source);
        end
    end

    ialu_core u_core (
        .i_opcode        (r_opcode),
        .i_operand_size  (r_operand_size),
        .i_operand_a     (r_operand_a),
        .i_operand_b     (r_operand_b),
        .i_extend_source (r_extend_source),
        .i_carry_in      (r_flags.cf),
        .o_result_value  (alu_result),
        .o_write_back    (alu_write_back),
        .o_flags         (alu_flags)
    );

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result_value <= alu_result;
            r_write_back   <= alu_write_back;
            r_out_flags    <= alu_flags;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_value  = r_result_value;
    assign o_res.write_back    = r_write_back;
    assign o_res.carry_out     = r_out_flags.cf;
    assign o_res.parity_out    = r_out_flags.pf;
    assign o_res.aux_carry_out = r_out_flags.af;
    assign o_res.zero_out      = r_out_flags.zf;
    assign o_res.sign_out      = r_out_flags.sf;
    assign o_res.overflow_out  = r_out_flags.of;

endmodule

FILE: rtl/ialu_core.sv
// Combinational ALU datapath: one shared adder plus logic ops and flag logic.
module ialu_core (
    input  ialu_pkg::t_opcode            i_opcode,
    input  logic [ialu_pkg::SIZE_W-1:0]  i_operand_size,
    input  logic [ialu_pkg::DATA_W-1:0]  i_operand_a,
    input  logic [ialu_pkg::DATA_W-1:0]  i_operand_b,
    input  ialu_pkg::t_ext               i_extend_source,
    input  logic                         i_carry_in,
    output logic [ialu_pkg::DATA_W-1:0]  o_result_value,
    output logic                         o_write_back,
    output ialu_pkg::t_flags             o_flags
);
    import ialu_pkg::*;

    logic [WIDTH_W-1:0] width_sel;
    logic [WIDTH_W-1:0] width_eff;
    logic [TOP_W-1:0]   top;
    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  b_ext;
    logic [DATA_W-1:0]  a_m;
    logic [DATA_W-1:0]  b_m;
    logic               is_sub;
    logic               use_cin;
    logic [DATA_W-1:0]  b_add;
    logic               ci;
    logic [DATA_W-1:0]  sum;
    logic [DATA_W-1:0]  r;
    logic [DATA_W-1:0]  cvec;
    logic [DATA_W-1:0]  ovec;
    logic               arith;

    // Operand width, limited to the datapath width
    assign width_sel = BASE_WIDTH << i_operand_size;
    assign width_eff = (width_sel > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_sel;
    assign top       = TOP_W'(width_eff - WIDTH_W'(1));
    assign mask      = (width_eff >= WIDTH_W'(DATA_W)) ? '1
                     : ((DATA_W'(1) << width_eff) - DATA_W'(1));

    always_comb begin
        unique case (i_extend_source)
            EXT_8:   b_ext = {{(DATA_W-8){i_operand_b[7]}},   i_operand_b[7:0]};
            EXT_16:  b_ext = {{(DATA_W-16){i_operand_b[15]}}, i_operand_b[15:0]};
            EXT_32:  b_ext = {{(DATA_W-32){i_operand_b[31]}}, i_operand_b[31:0]};
            default: b_ext = i_operand_b;
        endcase
    end

    assign a_m = i_operand_a & mask;
    assign b_m = b_ext & mask;

    // Subtract as a + ~b + 1 - borrow
    always_comb begin
        is_sub  = 1'b0;
        use_cin = 1'b0;
        arith   = 1'b1;
        unique case (i_opcode) inside
            OP_ADD:                 ;
            OP_ADC:                 use_cin = 1'b1;
            OP_SUB, OP_CMP:         is_sub  = 1'b1;
            OP_SBB: begin
                is_sub  = 1'b1;
                use_cin = 1'b1;
            end
            OP_AND, OP_OR, OP_XOR:  arith   = 1'b0;
            default:                arith   = 1'b0;
        endcase
    end

    assign b_add = is_sub ? ~b_m : b_m;
    assign ci    = is_sub ? ~(use_cin & i_carry_in) : (use_cin & i_carry_in);
    assign sum   = a_m + b_add + DATA_W'(ci);

    always_comb begin
        unique case (i_opcode) inside
            OP_AND:  r = a_m & b_m;
            OP_OR:   r = a_m | b_m;
            OP_XOR:  r = a_m ^ b_m;
            default: r = sum & mask;
        endcase
    end

    assign cvec = is_sub ? ((~a_m & b_m) | ((~a_m | b_m) & r))
                         : ((a_m & b_m) | ((a_m | b_m) & ~r));
    assign ovec = is_sub ? ((a_m ^ b_m) & (a_m ^ r))
                         : ((a_m ^ r) & (b_m ^ r));

    assign o_result_value = r;
    assign o_write_back   = (i_opcode != OP_CMP);
    assign o_flags.cf     = arith & cvec[top];
    assign o_flags.of     = arith & ovec[top];
    assign o_flags.af     = arith & (a_m[4] ^ b_m[4] ^ r[4]);
    assign o_flags.pf     = ~^r[7:0];
    assign o_flags.zf     = (r == '0);
    assign o_flags.sf     = r[top];

endmodule

FILE: rtl/ialu_checker.sv
`include "integer_alu_with_flags_macros.svh"

module ialu_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [ialu_pkg::DATA_W-1:0]  i_result_value,
    input  logic                         i_zero_out,
    input  logic                         i_sign_out,
    input  logic                         i_parity_out
);
    import ialu_pkg::*;

    // Stalled result holds
    `IALU_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_result_value), "result changed while stalled")

    // ZF, SF, PF agree with the result
    `IALU_ASSERT_IMPL(a_flag_consistent, i_out_valid, (i_zero_out == (i_result_value == '0)) && !(i_zero_out && i_sign_out) && (i_parity_out == ~^i_result_value[7:0]), "flags disagree with result")

    // Downstream ready never blocks the input
    `IALU_ASSERT_IMPL(a_ready_flow, i_out_ready, i_in_ready, "input blocked with output ready")

    // Accepted beat is followed by a valid result, through the input and result registers
    `IALU_ASSERT_DELAY(a_latency, i_in_valid && i_in_ready, 2, i_out_valid, "result missing after two cycles")

endmodule

bind integer_alu_with_flags ialu_checker u_ialu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_op.valid),
    .i_in_ready     (i_op.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_result_value (o_res.result_value),
    .i_zero_out     (o_res.zero_out),
    .i_sign_out     (o_res.sign_out),
    .i_parity_out   (o_res.parity_out)
);

FILE: test/ialu_flag_checker.sv
// Watches both ALU channels. Predicts each result from the operation beat and
// its own copy of the status flags, then compares results in order.
module ialu_flag_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ialu_op_if         i_op,
    ialu_res_if        i_res,
    output int         o_mismatches,
    output int         o_in_flight
);
    import ialu_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              write_back;
        t_flags            flags;
    } t_alu_outcome;

    t_alu_outcome pending_results[$];
    t_flags       flag_reg;
    int           mismatch_count = 0;
    int           result_beats   = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("ERROR result beat %0d: %s", result_beats, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] seen);
        if (seen !== want)
            report_mismatch($sformatf("%s expected %h got %h", name, want, seen));
    endtask

    task automatic check_flag(input string name, input logic want, input logic seen);
        if (seen !== want)
            report_mismatch($sformatf("%s expected %b got %b", name, want, seen));
    endtask

    // Result and flags of one operation; carry_in is the stored CF.
    function automatic t_alu_outcome alu_outcome(
        input t_opcode           op,
        input logic [SIZE_W-1:0] size,
        input logic [DATA_W-1:0] a_raw,
        input logic [DATA_W-1:0] b_raw,
        input t_ext              ext,
        input logic              carry_in
    );
        int unsigned       w;
        int unsigned       top;
        logic [DATA_W-1:0] mask, a, b, r, cin, cy, ov, hx;
        t_alu_outcome      o;
        w = int'(BASE_WIDTH) << size;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        top  = w - 1;
        mask = (w >= DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
        a = a_raw & mask;
        case (ext)
            EXT_8:   b = {{56{b_raw[7]}}, b_raw[7:0]};
            EXT_16:  b = {{48{b_raw[15]}}, b_raw[15:0]};
            EXT_32:  b = {{32{b_raw[31]}}, b_raw[31:0]};
            default: b = b_raw;
        endcase
        b   = b & mask;
        cin = {63'd0, carry_in};
        o   = '0;
        o.write_back = 1'b1;
        case (op)
            OP_ADD, OP_ADC: begin
                if (op == OP_ADD)
                    cin = '0;
                r  = (a + b + cin) & mask;
                cy = (a & b) | ((a | b) & ~r);
                ov = (a ^ r) & (b ^ r);
                hx = a ^ b ^ r;
                o.flags.cf = cy[top];
                o.flags.of = ov[top];
                o.flags.af = hx[4];
            end
            OP_SUB, OP_SBB, OP_CMP: begin
                if (op != OP_SBB)
                    cin = '0;
                if (op == OP_CMP)
                    o.write_back = 1'b0;
                r  = (a - b - cin) & mask;
                cy = (~a & b) | ((~a | b) & r);
                ov = (a ^ b) & (a ^ r);
                hx = a ^ b ^ r;
                o.flags.cf = cy[top];
                o.flags.of = ov[top];
                o.flags.af = hx[4];
            end
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            default: r = a ^ b;
        endcase
        o.value    = r;
        o.flags.pf = ~^r[7:0];
        o.flags.zf = (r == '0);
        o.flags.sf = r[top];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_alu_outcome want;
        if (!i_rst_n) begin
            pending_results.delete();
            flag_reg = '0;
            o_in_flight <= 0;
        end else begin
            // retire first: a result never belongs to the op taken at this edge
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no operation outstanding");
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_value", want.value, i_res.result_value);
                    check_flag("write_back", want.write_back, i_res.write_back);
                    check_flag("carry_out", want.flags.cf, i_res.carry_out);
                    check_flag("parity_out", want.flags.pf, i_res.parity_out);
                    check_flag("aux_carry_out", want.flags.af, i_res.aux_carry_out);
                    check_flag("zero_out", want.flags.zf, i_res.zero_out);
                    check_flag("sign_out", want.flags.sf, i_res.sign_out);
                    check_flag("overflow_out", want.flags.of, i_res.overflow_out);
                end
                result_beats++;
            end
            if (i_op.valid && i_op.ready) begin
                want = alu_outcome(t_opcode'(i_op.opcode), i_op.operand_size,
                                   i_op.operand_a, i_op.operand_b,
                                   t_ext'(i_op.extend_source), flag_reg.cf);
                flag_reg = want.flags;
                pending_results.push_back(want);
            end
            o_in_flight <= pending_results.size();
        end
    end

endmodule

FILE: test/tb_integer_alu_with_flags.sv
// Top of the ALU bench: clock, reset, operation stimulus, result-side
// back-pressure and the verdict. Result checking lives in ialu_flag_checker.
module tb_integer_alu_with_flags;
    import ialu_pkg::*;

    localparam int RANDOM_ITEMS   = 850;
    // last stretch of the random part runs with both sides always on
    localparam int CALM_TAIL      = 150;
    // quiet cycles (no beat on either side) before the run is declared hung;
    // far above the worst gap plus stall plus the pipe
    localparam int WATCHDOG_LIMIT = 1000;
    // settle time after the last result, a little over the pipe latency
    localparam int DRAIN_CYCLES   = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic stall_en;      // allows idle bursts on both sides
    int   stall_left;
    int   quiet_cycles;
    int   mismatches;
    int   in_flight;

    ialu_op_if  op_bus ();
    ialu_res_if res_bus ();

    integer_alu_with_flags DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_bus),
        .o_res   (res_bus)
    );

    ialu_flag_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op_bus),
        .i_res        (res_bus),
        .o_mismatches (mismatches),
        .o_in_flight  (in_flight)
    );

    always #6 i_clk = ~i_clk;

    // Result-side back-pressure: ready drops at random while stalling is
    // allowed, otherwise it stays high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            if (stall_left == 1)
                res_bus.ready <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (stall_en && $urandom_range(0, 9) == 0) begin
            res_bus.ready <= 1'b0;
            stall_left    <= $urandom_range(1, 14);
        end
    end

    // Hang detector: counts cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (op_bus.valid && op_bus.ready) ||
            (res_bus.valid && res_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("integer_alu_with_flags test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one operation and holds it until the beat is taken. Returns at
    // the accepting edge so the next item can follow back to back.
    task automatic send_op(input t_opcode op, input logic [SIZE_W-1:0] size,
                           input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                           input t_ext ext);
        op_bus.valid         <= 1'b1;
        op_bus.opcode        <= op;
        op_bus.operand_size  <= size;
        op_bus.operand_a     <= a;
        op_bus.operand_b     <= b;
        op_bus.extend_source <= ext;
        do @(posedge i_clk); while (op_bus.ready !== 1'b1);
    endtask

    // Operand mix: corners (zero, all ones, single bit, single hole, small)
    // mixed in with fully random values.
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'd1 << $urandom_range(0, 63);
            3:       v = ~(64'd1 << $urandom_range(0, 63));
            4:       v = v & 64'hFF;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic idle_phase;
        op_bus.valid         <= 1'b0;
        op_bus.opcode        <= OP_ADD;
        op_bus.operand_size  <= '0;
        op_bus.operand_a     <= '0;
        op_bus.operand_b     <= '0;
        op_bus.extend_source <= EXT_NONE;
        stall_en             <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, back to back. Size codes: 0=8, 1=16, 2=32, 3=64.
        // 8-bit wrap to zero with junk above the width: CF, ZF, AF
        send_op(OP_ADD, 2'd0, '1, 64'h01, EXT_NONE);
        // adc picks up that carry: 7F + 0 + 1 overflows to 80
        send_op(OP_ADC, 2'd0, 64'h7F, 64'h00, EXT_NONE);
        // 16-bit borrow, then sbb with stored borrow: 8000 - 0 - 1 overflows
        send_op(OP_SUB, 2'd1, 64'h0000, 64'h0001, EXT_NONE);
        send_op(OP_SBB, 2'd1, 64'h8000, 64'h0000, EXT_NONE);
        // compare: difference out, no write-back, signed overflow
        send_op(OP_CMP, 2'd2, 64'h8000_0000, 64'h1, EXT_NONE);
        // logic ops clear CF/OF/AF whatever came before
        send_op(OP_AND, 2'd3, '1, '1, EXT_NONE);
        send_op(OP_OR,  2'd3, '0, '0, EXT_NONE);
        send_op(OP_XOR, 2'd2, 64'hDEAD_BEEF_1234_5678, 64'hDEAD_BEEF_1234_5678,
                EXT_NONE);
        // 64-bit signed overflow, full carry chain, borrow through everything
        send_op(OP_ADD, 2'd3, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1, EXT_NONE);
        send_op(OP_ADC, 2'd3, '1, '1, EXT_NONE);
        send_op(OP_SBB, 2'd3, '0, '0, EXT_NONE);
        // sign extension of b from each source width
        send_op(OP_ADD, 2'd1, 64'h0001, 64'hFF, EXT_8);
        send_op(OP_ADD, 2'd2, 64'h0, 64'h8000, EXT_16);
        send_op(OP_ADD, 2'd3, 64'h0, 64'h8000_0000, EXT_32);
        send_op(OP_ADD, 2'd3, 64'h0, 64'hFFFF_FF7F, EXT_8);
        // source not narrower than the width: b is only cut
        send_op(OP_SUB, 2'd0, 64'h00, 64'hFFFF_0080, EXT_8);
        send_op(OP_SUB, 2'd0, 64'h10, 64'h8000_0001, EXT_32);
        send_op(OP_CMP, 2'd1, 64'h7FFF, 64'h1_8000, EXT_16);
        send_op(OP_SBB, 2'd2, 64'h1, 64'hFFFF_FFFF_0000_0002, EXT_32);
        // parity on odd and even low bytes
        send_op(OP_XOR, 2'd0, 64'hA5, 64'h01, EXT_NONE);
        send_op(OP_OR,  2'd0, 64'hFF00_0000_0000_0003, 64'h0, EXT_NONE);
        // half carry and half borrow out of bit 3
        send_op(OP_ADD, 2'd2, 64'h0F, 64'h01, EXT_NONE);
        send_op(OP_SUB, 2'd2, 64'h10, 64'h01, EXT_NONE);
        // equal compare at 64 bits, then adc with carry clear
        send_op(OP_CMP, 2'd3, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                EXT_NONE);
        send_op(OP_ADC, 2'd2, 64'hFFFF_FFFF, 64'h0, EXT_NONE);

        // Random part. Idling comes in phases so some stretches run flat out,
        // and the tail runs with no idling at all.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_phase = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 120) % 3 != 2);
            stall_en <= idle_phase;
            if (idle_phase && $urandom_range(0, 7) == 0) begin
                op_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            send_op(t_opcode'($urandom_range(0, 7)), SIZE_W'($urandom_range(0, 3)),
                    pick_operand(), pick_operand(), t_ext'($urandom_range(0, 3)));
        end
        op_bus.valid <= 1'b0;

        // one edge first so the in-flight count covers the last beat
        @(posedge i_clk);
        while (in_flight != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("integer_alu_with_flags test passed");
        else
            $display("integer_alu_with_flags test failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ialu_pkg.sv
rtl/ialu_op_if.sv
rtl/ialu_res_if.sv
rtl/ialu_core.sv
rtl/integer_alu_with_flags.sv
rtl/ialu_checker.sv
test/ialu_flag_checker.sv
test/tb_integer_alu_with_flags.sv
